@@ rtl/core/fsda_pkg.sv @@
// Shared types and constants for the fixed-width signed decimal ASCII framer.
package fsda_pkg;

	// Width of the magnitude field and the number of decimal digits it can need.
	localparam int VALUE_WIDTH       = 32;
	localparam int NUM_DIGITS        = (VALUE_WIDTH * 30103) / 100000 + 1;

	// Frame geometry.
	localparam int MAX_FRAME_DEFAULT = 16;
	localparam int FRAME_REG_W       = 5;
	localparam logic [FRAME_REG_W-1:0] FRAME_RESET = 5'd11;

	// Character codes.
	localparam logic [7:0] ASCII_ZERO  = 8'h30;
	localparam logic [7:0] ASCII_MINUS = 8'h2D;

	typedef logic [3:0] digit_t;
	typedef digit_t [NUM_DIGITS-1:0] digits_t;

	typedef struct packed {
		logic [VALUE_WIDTH-1:0] magnitude;
		logic                   negative;
	} in_item_t;

	typedef struct packed {
		logic [7:0] ascii_char;
		logic       last;
		logic       overflow;
	} out_item_t;

	// Status of the binary to BCD converter.
	typedef struct packed {
		logic busy;
		logic done;
	} conv_status_t;

endpackage

@@ rtl/core/fixed_width_signed_decimal_ascii.sv @@
// Top level of the fixed-width signed decimal ASCII framer.
//
// A request on the input channel carries an unsigned magnitude and a negative
// flag. The block answers with one frame of characters, one per request on
// the output channel, most significant first: right-aligned decimal digits,
// padded on the left with '0', and '-' in the first place when negative is
// set. The final character carries last. When the digits and sign do not
// fit, the low-order digits are kept, the sign is still placed and every
// character of the frame carries overflow.
// The configuration channel writes the frame width (reset value 11); zero
// counts as one and values above MAX_FRAME count as MAX_FRAME. It is always
// ready. It is to be written only while the block is idle; the block itself
// does not enforce this. Timing: the magnitude is converted to BCD one bit
// per cycle, followed by a check for overflow in S_CHECK. The frame then
// leaves at one character per cycle while the receiver does not stall.
// A stalled receiver holds the current character in the output register and
// pauses the frame. The next input request is taken while the final
// character still waits there. Reset empties the output register and
// returns the block to idle with the frame width at its reset value.
module fixed_width_signed_decimal_ascii #(
	parameter int MAX_FRAME = fsda_pkg::MAX_FRAME_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  fsda_pkg::in_item_t              in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output fsda_pkg::out_item_t             out_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [fsda_pkg::FRAME_REG_W-1:0] cfg_data
);
	import fsda_pkg::*;

	localparam int RW = $clog2(MAX_FRAME);
	localparam int FW = $clog2(MAX_FRAME + 1);
	localparam int XW = ((FRAME_REG_W > FW) ? FRAME_REG_W : FW) + 1;
	localparam int DW = $clog2(NUM_DIGITS);
	localparam int EW = ((RW > DW) ? RW : DW) + 1;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_CONV  = 4'b0010,
		S_CHECK = 4'b0100,
		S_EMIT  = 4'b1000
	} state_t;

	state_t                 state_q;
	logic [FRAME_REG_W-1:0] frame_q;
	logic                   neg_q;
	logic                   ovf_q;
	logic                   first_q;
	logic [RW-1:0]          r_q;
	logic                   out_valid_q;
	out_item_t              out_q;

	logic                   accept;
	logic                   load;
	digits_t                digits;
	conv_status_t           conv_status;
	logic [XW-1:0]          fw_raw;
	logic [XW-1:0]          fw_eff;
	logic [XW-1:0]          avail;
	logic                   ovf_c;
	logic [EW-1:0]          r_ext;
	digit_t                 sel_digit;
	logic [7:0]             char_c;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign load      = !out_valid_q || out_ready;

	fsda_bcd_conv u_conv (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (accept),
		.magnitude (in_data.magnitude),
		.digits    (digits),
		.status    (conv_status)
	);

	// Frame width register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= FRAME_RESET;
		end else if (cfg_valid) begin
			frame_q <= cfg_data;
		end
	end

	// Clamp the frame width and work out whether the digits fit beside the sign.
	always_comb begin
		fw_raw = XW'(frame_q);
		if (fw_raw == '0) begin
			fw_eff = XW'(1);
		end else if (fw_raw > XW'(MAX_FRAME)) begin
			fw_eff = XW'(MAX_FRAME);
		end else begin
			fw_eff = fw_raw;
		end
		avail = fw_eff - XW'(neg_q);
		ovf_c = (avail == '0);
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if ((XW'(i) >= avail) && (digits[i] != 4'd0)) begin
				ovf_c = 1'b1;
			end
		end
	end

	// Character at the current position; places beyond the converter are padding.
	always_comb begin
		r_ext     = EW'(r_q);
		sel_digit = digits[r_ext[DW-1:0]];
		if (neg_q && first_q) begin
			char_c = ASCII_MINUS;
		end else if (r_ext < EW'(NUM_DIGITS)) begin
			char_c = ASCII_ZERO + 8'(sel_digit);
		end else begin
			char_c = ASCII_ZERO;
		end
	end

	// Sequencer and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			first_q     <= 1'b0;
			r_q         <= '0;
		end else begin
			if ((state_q == S_EMIT) && load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_CONV;
					end
				end
				S_CONV: begin
					if (conv_status.done) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					first_q <= 1'b1;
					r_q     <= RW'(fw_eff - XW'(1));
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (load) begin
						first_q <= 1'b0;
						if (r_q == '0) begin
							state_q <= S_IDLE;
						end else begin
							r_q <= r_q - 1'b1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Per-item payload: sign, overflow flag and the output character register.
	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q <= in_data.negative;
		end
		if (state_q == S_CHECK) begin
			ovf_q <= ovf_c;
		end
		if ((state_q == S_EMIT) && load) begin
			out_q.ascii_char <= char_c;
			out_q.last       <= (r_q == '0);
			out_q.overflow   <= ovf_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// A character that is not the last is followed at once by the next one.
	a_frame_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_data.last |=> out_valid)
		else $error("frame broken after a non-final character");

	// The overflow flag does not change within a frame.
	a_ovf_steady: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_data.last |=>
			out_data.overflow == $past(out_data.overflow))
		else $error("overflow flag changed within a frame");

	// A new item is only taken once the previous frame has been fully loaded.
	a_accept_after_frame: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (!out_valid || out_data.last))
		else $error("input taken while a frame is still in progress");

	// The converter is running throughout the conversion state.
	a_conv_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CONV) |-> conv_status.busy)
		else $error("converter idle during conversion");

endmodule

@@ rtl/core/fsda_bcd_conv.sv @@
// Bit-serial binary to BCD converter using the shift-and-add-three method.
module fsda_bcd_conv (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [fsda_pkg::VALUE_WIDTH-1:0] magnitude,
	output fsda_pkg::digits_t               digits,
	output fsda_pkg::conv_status_t          status
);
	import fsda_pkg::*;

	localparam int CW = $clog2(VALUE_WIDTH);
	localparam logic [CW-1:0] LAST_BIT = CW'(VALUE_WIDTH - 1);

	logic [VALUE_WIDTH-1:0] mag_q;
	digits_t                digits_q;
	digits_t                adj;
	digits_t                digits_next;
	logic [CW-1:0]          cnt_q;
	logic                   busy_q;

	// Add three to every digit of five or more, then shift the whole word left
	// by one bit with the next magnitude bit entering at the bottom.
	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			adj[i] = (digits_q[i] >= 4'd5) ? digits_q[i] + 4'd3 : digits_q[i];
		end
		digits_next[0] = {adj[0][2:0], mag_q[VALUE_WIDTH-1]};
		for (int i = 1; i < NUM_DIGITS; i++) begin
			digits_next[i] = {adj[i][2:0], adj[i-1][3]};
		end
	end

	// Control: one magnitude bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == LAST_BIT) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Data shift registers.
	always_ff @(posedge clk) begin
		if (start) begin
			mag_q    <= magnitude;
			digits_q <= '0;
		end else if (busy_q) begin
			mag_q    <= {mag_q[VALUE_WIDTH-2:0], 1'b0};
			digits_q <= digits_next;
		end
	end

	assign digits      = digits_q;
	assign status.busy = busy_q;
	assign status.done = busy_q && (cnt_q == LAST_BIT);

endmodule
